// ----- hdl/ntt_pkg.sv -----
// ----------------------------------------------------------------------------
// ntt_pkg
// Shared types, constants and codes of the NAPT port translation table.
// ----------------------------------------------------------------------------
package ntt_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int PORT_SPACE    = 65536;
  localparam int ROW_W         = 5;                       // bits of port index within a row
  localparam int ROW_BITS      = 1 << ROW_W;
  localparam int ROWS          = PORT_SPACE / ROW_BITS;
  localparam int ROW_AW        = $clog2(ROWS);
  localparam int PEND_W        = 17;                      // holds 0..65536

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_EXTERNAL_ADDR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_LOW      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_HIGH     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT  = 8'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_IN_MISS = 3'd1;
  localparam logic [2:0] ST_NO_PORT = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_TICK    = 3'd4;

  localparam logic [7:0] FLAGS_FIN_ACK = 8'h11;
  localparam logic [7:0] FLAGS_RST     = 8'h04;

  localparam logic CMD_PACKET  = 1'b0;
  localparam logic DIR_INBOUND = 1'b1;

  typedef struct packed {
    logic [31:0] server_addr;
    logic [15:0] server_port;
    logic [31:0] inside_addr;
    logic [15:0] inside_port;
    logic [15:0] outside_port;
    logic [1:0]  fin_marks;
    logic [31:0] last_seen;
  } entry_t;

  typedef struct packed {
    logic out_hit;
    logic in_hit;
    logic expired;
  } match_t;

endpackage

// ----- hdl/ntt_if.sv -----
// ----------------------------------------------------------------------------
// ntt_in_if / ntt_out_if
// Valid/ready channels carrying packet or tick items and their results.
// ----------------------------------------------------------------------------
interface ntt_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic        direction;
  logic [31:0] src_addr;
  logic [15:0] src_port;
  logic [31:0] dst_addr;
  logic [15:0] dst_port;
  logic [7:0]  tcp_flags;
  logic [31:0] now_seconds;

  modport source (output valid, command, direction, src_addr, src_port, dst_addr,
                  dst_port, tcp_flags, now_seconds, input ready);
  modport sink   (input valid, command, direction, src_addr, src_port, dst_addr,
                  dst_port, tcp_flags, now_seconds, output ready);
endinterface

interface ntt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] new_addr;
  logic [15:0] new_port;
  logic        entry_freed;
  logic [8:0]  aged_count;

  modport source (output valid, status, new_addr, new_port, entry_freed, aged_count,
                  input ready);
  modport sink   (input valid, status, new_addr, new_port, entry_freed, aged_count,
                  output ready);
endinterface

// ----- hdl/ntt_match_unit.sv -----
// ----------------------------------------------------------------------------
// ntt_match_unit
// Shared compare unit: flow key match both ways and idle-age test of one entry.
// ----------------------------------------------------------------------------
module ntt_match_unit
  import ntt_pkg::*;
(
  input  entry_t      entry,
  input  logic [31:0] src_addr,
  input  logic [15:0] src_port,
  input  logic [31:0] dst_addr,
  input  logic [15:0] dst_port,
  input  logic [31:0] external_addr,
  input  logic [31:0] now_seconds,
  input  logic [31:0] idle_timeout,
  output match_t      result
);

  logic [31:0] idle;

  assign idle = now_seconds - entry.last_seen;

  always_comb begin
    result.out_hit = (entry.server_addr == dst_addr) && (entry.server_port == dst_port) &&
                     (entry.inside_addr == src_addr) && (entry.inside_port == src_port);
    result.in_hit  = (entry.server_addr == src_addr) && (entry.server_port == src_port) &&
                     (dst_addr == external_addr) && (entry.outside_port == dst_port);
    result.expired = idle > idle_timeout;
  end

endmodule

// ----- hdl/nat_port_translation_table_core.sv -----
// ----------------------------------------------------------------------------
// nat_port_translation_table_core
// NAPT table for TCP flows: lookup, port allocation, FIN/RST release, aging.
// ----------------------------------------------------------------------------
// Sequence: a packet reads and compares entries in order until a hit, then
//   updates it and reports, adding a bitmap read and write when an RST releases
//   it; a miss scans all TABLE_ENTRIES, then an outbound one searches free
//   ports one 32-port row at a time; a tick scans all entries, freeing aged ones.
// Throughput: one transaction at a time; the shared compare unit and the
//   single-port entry memory set the rate.
// Reset: entry valid bits clear at once; a clearing pass over all ROWS (2048)
//   bitmap rows then zeroes the port bitmap, with input ready held low.
// ----------------------------------------------------------------------------
module nat_port_translation_table_core
  import ntt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ntt_in_if.sink                in_ch,
  ntt_out_if.source             out_ch
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SCMP  = 4'd3;
  localparam logic [3:0] S_HIT   = 4'd4;
  localparam logic [3:0] S_MISS  = 4'd5;
  localparam logic [3:0] S_PRD   = 4'd6;
  localparam logic [3:0] S_PCMP  = 4'd7;
  localparam logic [3:0] S_RRD   = 4'd8;
  localparam logic [3:0] S_RWR   = 4'd9;
  localparam logic [3:0] S_ARD   = 4'd10;
  localparam logic [3:0] S_ACMP  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(ROWS - 1);

  // configuration registers
  logic [31:0] external_addr;
  logic [15:0] port_low;
  logic [15:0] port_high;
  logic [31:0] idle_timeout;

  // sequencer
  logic [3:0]        state;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  slot;
  logic              free_found;
  logic [ROW_AW-1:0] row;
  logic [15:0]       rel_port;
  logic [TABLE_ENTRIES-1:0] valid;

  // latched item
  logic        it_command;
  logic        it_dir;
  logic [31:0] it_src_addr;
  logic [15:0] it_src_port;
  logic [31:0] it_dst_addr;
  logic [15:0] it_dst_port;
  logic [7:0]  it_flags;
  logic [31:0] it_now;

  // pending result
  logic [2:0]  res_status;
  logic [31:0] res_addr;
  logic [15:0] res_port;
  logic        res_freed;
  logic [8:0]  res_aged;
  logic        out_valid;

  // memories
  entry_t                ent_mem [TABLE_ENTRIES];
  entry_t                ent_rd;
  entry_t                ent_hold;
  entry_t                ent_wdata;
  logic                  ent_we;
  logic                  ent_re;
  logic [IDX_W-1:0]      ent_waddr;
  logic [ROW_BITS-1:0]   bm_mem [ROWS];
  logic [ROW_BITS-1:0]   bm_rd;
  logic [ROW_BITS-1:0]   bm_wdata;
  logic                  bm_we;
  logic                  bm_re;
  logic [ROW_AW-1:0]     bm_waddr;
  logic [ROW_AW-1:0]     bm_raddr;

  match_t      match;
  logic [15:0] p0;
  logic [PEND_W-1:0] pend;
  logic [1:0]  fin_new;
  logic        rel_now;
  logic [ROW_BITS-1:0] free_bits;
  logic        port_hit;
  logic [ROW_W-1:0] port_bit;
  logic [PEND_W-1:0] next_row_base;

  assign in_ch.ready = (state == S_IDLE);

  assign out_ch.valid       = out_valid;

  // The compare unit sees the entry just read from memory.
  ntt_match_unit u_match (
    .entry         (ent_rd),
    .src_addr      (it_src_addr),
    .src_port      (it_src_port),
    .dst_addr      (it_dst_addr),
    .dst_port      (it_dst_port),
    .external_addr (external_addr),
    .now_seconds   (it_now),
    .idle_timeout  (idle_timeout),
    .result        (match)
  );

  // Search window for free ports: port zero never assigned, stop before port_high.
  assign p0   = (port_low == 16'd0) ? 16'd1 : port_low;
  assign pend = ({1'b0, port_high} < PEND_W'(PORT_SPACE)) ? {1'b0, port_high}
                                                          : PEND_W'(PORT_SPACE);
  assign next_row_base = PEND_W'({({1'b0, row} + 1'b1), {ROW_W{1'b0}}});

  // FIN marks: bit0 from inbound, bit1 from outbound FIN+ACK.
  always_comb begin
    fin_new = ent_hold.fin_marks;
    if (it_flags == FLAGS_FIN_ACK) begin
      fin_new = fin_new | ((it_dir == DIR_INBOUND) ? 2'b01 : 2'b10);
    end
    rel_now = (it_flags == FLAGS_RST) && (fin_new == 2'b11);
  end

  // Lowest free port in the current bitmap row inside the window.
  always_comb begin
    port_hit = 1'b0;
    port_bit = '0;
    for (int b = 0; b < ROW_BITS; b++) begin
      free_bits[b] = !bm_rd[b] &&
                     (PEND_W'({row, ROW_W'(b)}) >= PEND_W'(p0)) &&
                     (PEND_W'({row, ROW_W'(b)}) < pend);
    end
    for (int b = ROW_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        port_hit = 1'b1;
        port_bit = ROW_W'(b);
      end
    end
  end

  // memory write ports
  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = idx;
    ent_wdata = ent_hold;
    ent_re    = (state == S_SRD) || (state == S_ARD);
    bm_we     = 1'b0;
    bm_waddr  = row;
    bm_wdata  = '0;
    bm_re     = (state == S_PRD) || (state == S_RRD);
    bm_raddr  = (state == S_RRD) ? rel_port[ROW_W +: ROW_AW] : row;
    case (state)
      S_CLEAR: begin
        bm_we = 1'b1;
      end
      S_HIT: begin
        ent_we              = 1'b1;
        ent_wdata.last_seen = it_now;
        ent_wdata.fin_marks = fin_new;
      end
      S_PCMP: begin
        if (port_hit) begin
          ent_we                 = 1'b1;
          ent_waddr              = slot;
          ent_wdata.server_addr  = it_dst_addr;
          ent_wdata.server_port  = it_dst_port;
          ent_wdata.inside_addr  = it_src_addr;
          ent_wdata.inside_port  = it_src_port;
          ent_wdata.outside_port = 16'({row, port_bit});
          ent_wdata.fin_marks    = (it_flags == FLAGS_FIN_ACK) ? 2'b10 : 2'b00;
          ent_wdata.last_seen    = it_now;
          bm_we                  = 1'b1;
          bm_wdata               = bm_rd | (ROW_BITS'(1) << port_bit);
        end
      end
      S_RWR: begin
        bm_we    = 1'b1;
        bm_waddr = rel_port[ROW_W +: ROW_AW];
        bm_wdata = bm_rd & ~(ROW_BITS'(1) << rel_port[ROW_W-1:0]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rd <= ent_mem[idx];
    end
    if (bm_we) begin
      bm_mem[bm_waddr] <= bm_wdata;
    end
    if (bm_re) begin
      bm_rd <= bm_mem[bm_raddr];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      external_addr <= 32'd0;
      port_low      <= 16'd1024;
      port_high     <= 16'd65535;
      idle_timeout  <= 32'd60;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EXTERNAL_ADDR: external_addr <= cfg_data[31:0];
        REG_PORT_LOW:      port_low      <= cfg_data[15:0];
        REG_PORT_HIGH:     port_high     <= cfg_data[15:0];
        REG_IDLE_TIMEOUT:  idle_timeout  <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  // item latch and held entry
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      it_command  <= in_ch.command;
      it_dir      <= in_ch.direction;
      it_src_addr <= in_ch.src_addr;
      it_src_port <= in_ch.src_port;
      it_dst_addr <= in_ch.dst_addr;
      it_dst_port <= in_ch.dst_port;
      it_flags    <= in_ch.tcp_flags;
      it_now      <= in_ch.now_seconds;
    end
    if (state == S_SCMP) begin
      ent_hold <= ent_rd;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      row        <= '0;
      idx        <= '0;
      slot       <= '0;
      free_found <= 1'b0;
      valid      <= '0;
      out_valid  <= 1'b0;
      res_status <= ST_OK;
      res_addr   <= '0;
      res_port   <= '0;
      res_freed  <= 1'b0;
      res_aged   <= '0;
      rel_port   <= '0;
    end else begin
      if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          row <= row + 1'b1;
          if (row == ROW_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            idx        <= '0;
            free_found <= 1'b0;
            res_status <= ST_OK;
            res_addr   <= '0;
            res_port   <= '0;
            res_freed  <= 1'b0;
            res_aged   <= '0;
            state      <= (in_ch.command == CMD_PACKET) ? S_SRD : S_ARD;
          end
        end
        S_SRD: begin
          state <= S_SCMP;
        end
        S_SCMP: begin
          // lowest matching entry wins; remember the first free slot
          if (valid[idx] && ((it_dir == DIR_INBOUND) ? match.in_hit : match.out_hit)) begin
            state <= S_HIT;
          end else begin
            if (!valid[idx] && !free_found) begin
              free_found <= 1'b1;
              slot       <= idx;
            end
            if (idx == IDX_LAST) begin
              state <= S_MISS;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_SRD;
            end
          end
        end
        S_HIT: begin
          res_status <= ST_OK;
          res_addr   <= (it_dir == DIR_INBOUND) ? ent_hold.inside_addr : external_addr;
          res_port   <= (it_dir == DIR_INBOUND) ? ent_hold.inside_port
                                                : ent_hold.outside_port;
          res_freed  <= rel_now;
          if (rel_now) begin
            valid[idx] <= 1'b0;
            rel_port   <= ent_hold.outside_port;
            state      <= S_RRD;
          end else begin
            state <= S_DONE;
          end
        end
        S_MISS: begin
          if (it_dir == DIR_INBOUND) begin
            res_status <= ST_IN_MISS;
            state      <= S_DONE;
          end else if (!free_found) begin
            res_status <= ST_FULL;
            state      <= S_DONE;
          end else if (PEND_W'(p0) >= pend) begin
            res_status <= ST_NO_PORT;
            state      <= S_DONE;
          end else begin
            row   <= p0[ROW_W +: ROW_AW];
            state <= S_PRD;
          end
        end
        S_PRD: begin
          state <= S_PCMP;
        end
        S_PCMP: begin
          if (port_hit) begin
            valid[slot] <= 1'b1;
            res_status  <= ST_OK;
            res_addr    <= external_addr;
            res_port    <= 16'({row, port_bit});
            state       <= S_DONE;
          end else if (next_row_base >= pend) begin
            res_status <= ST_NO_PORT;
            state      <= S_DONE;
          end else begin
            row   <= row + 1'b1;
            state <= S_PRD;
          end
        end
        S_RRD: begin
          state <= S_RWR;
        end
        S_RWR: begin
          // release done: resume the sweep on a tick, else report
          if (it_command == CMD_PACKET) begin
            state <= S_DONE;
          end else if (idx == IDX_LAST) begin
            res_status <= ST_TICK;
            state      <= S_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_ARD;
          end
        end
        S_ARD: begin
          state <= S_ACMP;
        end
        S_ACMP: begin
          if (valid[idx] && match.expired) begin
            valid[idx] <= 1'b0;
            rel_port   <= ent_rd.outside_port;
            if (res_aged != 9'd511) begin
              res_aged <= res_aged + 1'b1;
            end
            state <= S_RRD;
          end else if (idx == IDX_LAST) begin
            res_status <= ST_TICK;
            state      <= S_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_ARD;
          end
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ch.ready)) begin
      out_ch.status      <= res_status;
      out_ch.new_addr    <= res_addr;
      out_ch.new_port    <= res_port;
      out_ch.entry_freed <= res_freed;
      out_ch.aged_count  <= res_aged;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (state != S_IDLE))
    else $error("accepted transaction did not start the sequencer");

  a_tick_status_only_for_tick: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_status == ST_TICK) |-> (it_command != CMD_PACKET))
    else $error("tick status on a packet transaction");

  a_insert_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_PCMP && port_hit) |-> !valid[slot])
    else $error("insert over a valid entry");

  a_freed_only_on_packet: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_freed) |-> (res_status == ST_OK))
    else $error("entry freed without a translated hit");

endmodule

// ----- tb/tb_nat_port_translation_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nat_port_translation_table_core
// Self-checking bench for the NAPT port translation table: a directed table
// of flow setup, FIN/RST release and aging, then random phases under several
// port ranges and timeouts, scored against a local table model or hand-typed rows.
// ----------------------------------------------------------------------------
module tb_nat_port_translation_table_core;
  import ntt_pkg::*;

  localparam logic CMD_TICK     = 1'b1;
  localparam logic DIR_OUTBOUND = 1'b0;
  localparam logic [7:0] FLAGS_SYN = 8'h02;
  localparam logic [7:0] FLAGS_ACK = 8'h10;
  localparam int   CYCLE_LIMIT  = 20000000;
  localparam int   HOLD_CYCLES  = 4000;
  localparam int   POOL_MAX     = 16;

  typedef struct {
    logic        command;
    logic        direction;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [31:0] dst_addr;
    logic [15:0] dst_port;
    logic [7:0]  tcp_flags;
    logic [31:0] now_seconds;
  } pkt_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] new_addr;
    logic [15:0] new_port;
    logic        entry_freed;
    logic [8:0]  aged_count;
  } res_t;

  typedef struct {
    pkt_t pkt;
    bit   typed;
    res_t res;
  } row_t;

  typedef struct {
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [31:0] in_addr;
    logic [15:0] in_port;
  } flow_t;

  typedef struct {
    logic [31:0] ext;
    logic [15:0] low;
    logic [15:0] high;
    logic [31:0] timeout;
    int          items;
    int          fresh_pct;
    bit          calm_clock;
  } phase_t;

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ntt_in_if  in_ch ();
  ntt_out_if out_ch ();

  nat_port_translation_table_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  // Mirror of the translation table, the port bitmap and the registers.
  bit          tbl_valid [TABLE_ENTRIES];
  logic [31:0] tbl_peer_addr [TABLE_ENTRIES];
  logic [15:0] tbl_peer_port [TABLE_ENTRIES];
  logic [31:0] tbl_in_addr [TABLE_ENTRIES];
  logic [15:0] tbl_in_port [TABLE_ENTRIES];
  logic [15:0] tbl_out_port [TABLE_ENTRIES];
  logic [1:0]  tbl_fin [TABLE_ENTRIES];
  logic [31:0] tbl_seen [TABLE_ENTRIES];
  bit          port_busy [PORT_SPACE];
  logic [31:0] reg_ext;
  logic [15:0] reg_low;
  logic [15:0] reg_high;
  logic [31:0] reg_timeout;

  res_t        pending_results[$];
  flow_t       flow_pool[$];
  row_t        directed_rows[$];
  int          errors;
  int          cycles;
  bit          hold_req;
  logic [31:0] clock_now;

  // Clock, and the cycle counter that bounds the run.
  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = ~clk;
    end
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("nat_port_translation_table_core verification failed");
    $finish;
  end

  // Free an entry and give its outside port back to the pool.
  function automatic void drop_entry(int i);
    port_busy[tbl_out_port[i]] = 1'b0;
    tbl_valid[i] = 1'b0;
  endfunction

  // Compute the result of one accepted transaction and advance the table.
  function automatic res_t translate(pkt_t p);
    res_t        r;
    int          hit;
    int          slot;
    int          pt;
    logic [31:0] idle;
    r = '{ST_OK, 32'd0, 16'd0, 1'b0, 9'd0};
    hit = -1;
    if (p.command == CMD_TICK) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        idle = p.now_seconds - tbl_seen[i];
        if (tbl_valid[i] && idle > reg_timeout) begin
          drop_entry(i);
          if (r.aged_count < 9'd511) r.aged_count++;
        end
      end
      r.status = ST_TICK;
      return r;
    end
    if (p.direction == DIR_OUTBOUND) begin
      for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++)
        if (tbl_valid[i] && tbl_peer_addr[i] == p.dst_addr && tbl_peer_port[i] == p.dst_port &&
            tbl_in_addr[i] == p.src_addr && tbl_in_port[i] == p.src_port)
          hit = i;
      if (hit < 0) begin
        // Entry first, then port; a failure leaves the table untouched.
        slot = -1;
        for (int i = 0; i < TABLE_ENTRIES && slot < 0; i++)
          if (!tbl_valid[i]) slot = i;
        if (slot < 0) begin
          r.status = ST_FULL;
        end else begin
          pt = (reg_low < 1) ? 1 : int'(reg_low);
          while (pt < int'(reg_high) && pt < PORT_SPACE && port_busy[pt]) pt++;
          if (pt >= int'(reg_high) || pt >= PORT_SPACE) begin
            r.status = ST_NO_PORT;
          end else begin
            port_busy[pt]       = 1'b1;
            tbl_valid[slot]     = 1'b1;
            tbl_peer_addr[slot] = p.dst_addr;
            tbl_peer_port[slot] = p.dst_port;
            tbl_in_addr[slot]   = p.src_addr;
            tbl_in_port[slot]   = p.src_port;
            tbl_out_port[slot]  = pt[15:0];
            tbl_fin[slot]       = 2'b00;
            hit = slot;
          end
        end
      end
      if (hit >= 0) begin
        r.new_addr = reg_ext;
        r.new_port = tbl_out_port[hit];
      end
    end else begin
      for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++)
        if (tbl_valid[i] && tbl_peer_addr[i] == p.src_addr && tbl_peer_port[i] == p.src_port &&
            p.dst_addr == reg_ext && tbl_out_port[i] == p.dst_port)
          hit = i;
      if (hit < 0) begin
        r.status = ST_IN_MISS;
      end else begin
        r.new_addr = tbl_in_addr[hit];
        r.new_port = tbl_in_port[hit];
      end
    end
    if (hit >= 0) begin
      tbl_seen[hit] = p.now_seconds;
      // Only the exact flag bytes count: FIN+ACK marks, RST releases.
      if (p.tcp_flags == FLAGS_FIN_ACK)
        tbl_fin[hit] |= (p.direction == DIR_INBOUND) ? 2'b01 : 2'b10;
      if (p.tcp_flags == FLAGS_RST && tbl_fin[hit] == 2'b11) begin
        drop_entry(hit);
        r.entry_freed = 1'b1;
      end
    end
    return r;
  endfunction

  // Scoreboard: predict on input transactions, compare on output ones.
  row_t typed_next[$];

  always @(posedge clk) begin
    res_t predicted;
    res_t got;
    res_t want;
    if (!rst && in_ch.valid && in_ch.ready) begin
      predicted = translate('{in_ch.command, in_ch.direction, in_ch.src_addr,
                              in_ch.src_port, in_ch.dst_addr, in_ch.dst_port,
                              in_ch.tcp_flags, in_ch.now_seconds});
      // A hand-typed expectation overrides the model for directed rows.
      if (typed_next.size() != 0 && typed_next[0].typed) predicted = typed_next[0].res;
      if (typed_next.size() != 0) void'(typed_next.pop_front());
      pending_results.push_back(predicted);
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.new_addr, out_ch.new_port, out_ch.entry_freed,
              out_ch.aged_count};
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %p", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t status: expected %0d, actual %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.new_addr !== want.new_addr) begin
          $display("%0t new_addr: expected %h, actual %h", $time, want.new_addr, got.new_addr);
          errors++;
        end
        if (got.new_port !== want.new_port) begin
          $display("%0t new_port: expected %0d, actual %0d", $time, want.new_port,
                   got.new_port);
          errors++;
        end
        if (got.entry_freed !== want.entry_freed) begin
          $display("%0t entry_freed: expected %b, actual %b", $time, want.entry_freed,
                   got.entry_freed);
          errors++;
        end
        if (got.aged_count !== want.aged_count) begin
          $display("%0t aged_count: expected %0d, actual %0d", $time, want.aged_count,
                   got.aged_count);
          errors++;
        end
      end
    end
  end

  // Result side: switch stall patterns now and then, and honor a long hold-off.
  initial begin
    int mode;
    int left;
    out_ch.ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = $urandom_range(0, 1);
        default: out_ch.ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Present one transaction at the falling edge and hold it until taken.
  task automatic send(pkt_t p);
    @(negedge clk);
    in_ch.valid       = 1'b1;
    in_ch.command     = p.command;
    in_ch.direction   = p.direction;
    in_ch.src_addr    = p.src_addr;
    in_ch.src_port    = p.src_port;
    in_ch.dst_addr    = p.dst_addr;
    in_ch.dst_port    = p.dst_port;
    in_ch.tcp_flags   = p.tcp_flags;
    in_ch.now_seconds = p.now_seconds;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic idle_input(int n);
    repeat (n) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
  endtask

  // Wait until every outstanding result has come back.
  task automatic drain();
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    in_ch.valid = 1'b0;
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    case (idx)
      REG_EXTERNAL_ADDR: reg_ext     = val;
      REG_PORT_LOW:      reg_low     = val[15:0];
      REG_PORT_HIGH:     reg_high    = val[15:0];
      REG_IDLE_TIMEOUT:  reg_timeout = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic pkt_t mk(logic cmd, logic dir, logic [31:0] sa, logic [15:0] sp,
                              logic [31:0] da, logic [15:0] dp, logic [7:0] fl,
                              logic [31:0] now);
    mk = '{cmd, dir, sa, sp, da, dp, fl, now};
  endfunction

  function automatic logic [7:0] pick_flags();
    case ($urandom_range(0, 5))
      0: return FLAGS_FIN_ACK;
      1: return FLAGS_RST;
      2: return FLAGS_SYN;
      3: return $urandom_range(0, 255);
      default: return FLAGS_ACK;
    endcase
  endfunction

  function automatic flow_t fresh_flow();
    fresh_flow = '{$urandom, $urandom_range(0, 65535), $urandom, $urandom_range(0, 65535)};
  endfunction

  // Build one random transaction, mixing fresh, pooled and live flows with ticks.
  function automatic pkt_t next_packet(phase_t ph);
    pkt_t  p;
    flow_t f;
    int    roll;
    int    e;
    if (ph.calm_clock || $urandom_range(0, 99) > 2) clock_now += $urandom_range(0, 3);
    else if ($urandom_range(0, 1) == 0) clock_now += $urandom_range(0, 400);
    else clock_now = $urandom;
    p = mk(CMD_PACKET, DIR_OUTBOUND, 0, 0, 0, 0, pick_flags(), clock_now);
    roll = $urandom_range(0, 99);
    if (roll < ph.fresh_pct || flow_pool.size() == 0) begin
      f = fresh_flow();
      if (flow_pool.size() >= POOL_MAX) flow_pool[$urandom_range(0, POOL_MAX - 1)] = f;
      else flow_pool.push_back(f);
      p.src_addr = f.in_addr;   p.src_port = f.in_port;
      p.dst_addr = f.peer_addr; p.dst_port = f.peer_port;
    end else if (roll < 50) begin
      f = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
      p.src_addr = f.in_addr;   p.src_port = f.in_port;
      p.dst_addr = f.peer_addr; p.dst_port = f.peer_port;
    end else if (roll < 78) begin
      // Inbound against a live entry, so the reverse path really hits.
      e = $urandom_range(0, TABLE_ENTRIES - 1);
      for (int k = 0; k < TABLE_ENTRIES && !tbl_valid[e]; k++) e = (e + 1) % TABLE_ENTRIES;
      p.direction = DIR_INBOUND;
      p.src_addr = tbl_peer_addr[e]; p.src_port = tbl_peer_port[e];
      p.dst_addr = reg_ext;          p.dst_port = tbl_out_port[e];
      if (!tbl_valid[e]) p.dst_port = $urandom_range(0, 65535);
      else if ($urandom_range(0, 9) == 0) p.dst_addr = reg_ext ^ (32'd1 << $urandom_range(0, 31));
    end else if (roll < 84) begin
      p.command = CMD_TICK;
      p.direction = $urandom_range(0, 1);
      p.src_addr = $urandom;
    end else begin
      p = mk(($urandom_range(0, 19) == 0) ? CMD_TICK : CMD_PACKET, $urandom_range(0, 1),
             $urandom, $urandom_range(0, 65535), $urandom, $urandom_range(0, 65535),
             $urandom_range(0, 255), ph.calm_clock ? clock_now : $urandom);
    end
    return p;
  endfunction

  initial begin
    localparam logic [31:0] EXT = 32'hC0A8_0001;
    localparam logic [31:0] SRV = 32'h5DB8_D822;
    localparam logic [31:0] INS = 32'h0A00_0001;
    phase_t phases[5];
    int     burst;
    pkt_t   p;

    errors = 0;
    cycles = 0;
    hold_req = 1'b0;
    clock_now = 32'd100;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_PACKET;
    in_ch.direction = DIR_OUTBOUND;
    in_ch.src_addr = '0;
    in_ch.src_port = '0;
    in_ch.dst_addr = '0;
    in_ch.dst_port = '0;
    in_ch.tcp_flags = '0;
    in_ch.now_seconds = '0;
    reg_ext = 32'd0;
    reg_low = 16'd1024;
    reg_high = 16'd65535;
    reg_timeout = 32'd60;
    foreach (tbl_valid[i]) begin
      tbl_valid[i] = 1'b0;
      tbl_peer_addr[i] = '0;
      tbl_peer_port[i] = '0;
      tbl_in_addr[i] = '0;
      tbl_in_port[i] = '0;
      tbl_out_port[i] = '0;
      tbl_fin[i] = '0;
      tbl_seen[i] = '0;
    end
    foreach (port_busy[i]) port_busy[i] = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_reg(REG_EXTERNAL_ADDR, EXT);

    // Directed rows under reset defaults (ports from 1024, timeout 60).
    directed_rows = '{
      '{mk(CMD_TICK, DIR_OUTBOUND, 0, 0, 0, 0, 0, 0), 1, '{ST_TICK, 0, 0, 0, 0}},
      '{mk(CMD_PACKET, DIR_INBOUND, SRV, 80, EXT, 1024, FLAGS_ACK, 0), 1,
        '{ST_IN_MISS, 0, 0, 0, 0}},
      '{mk(CMD_PACKET, DIR_OUTBOUND, INS, 5000, SRV, 80, FLAGS_SYN, 1), 1,
        '{ST_OK, EXT, 1024, 0, 0}},
      '{mk(CMD_PACKET, DIR_OUTBOUND, '1, '1, '1, '1, '1, '1), 1, '{ST_OK, EXT, 1025, 0, 0}},
      '{mk(CMD_PACKET, DIR_OUTBOUND, 0, 0, 0, 0, 0, 2), 1, '{ST_OK, EXT, 1026, 0, 0}},
      '{mk(CMD_PACKET, DIR_INBOUND, SRV, 80, EXT, 1024, FLAGS_ACK, 3), 1,
        '{ST_OK, INS, 5000, 0, 0}},
      '{mk(CMD_PACKET, DIR_INBOUND, SRV, 80, EXT ^ 32'd1, 1024, FLAGS_ACK, 3), 1,
        '{ST_IN_MISS, 0, 0, 0, 0}},
      '{mk(CMD_PACKET, DIR_OUTBOUND, INS, 5000, SRV, 80, 8'h13, 4), 1,
        '{ST_OK, EXT, 1024, 0, 0}},
      '{mk(CMD_PACKET, DIR_OUTBOUND, INS, 5000, SRV, 80, FLAGS_RST, 5), 1,
        '{ST_OK, EXT, 1024, 0, 0}},
      '{mk(CMD_PACKET, DIR_OUTBOUND, INS, 5000, SRV, 80, FLAGS_FIN_ACK, 6), 1,
        '{ST_OK, EXT, 1024, 0, 0}},
      '{mk(CMD_PACKET, DIR_INBOUND, SRV, 80, EXT, 1024, FLAGS_FIN_ACK, 7), 1,
        '{ST_OK, INS, 5000, 0, 0}},
      '{mk(CMD_PACKET, DIR_INBOUND, SRV, 80, EXT, 1024, FLAGS_RST, 8), 1,
        '{ST_OK, INS, 5000, 1, 0}},
      '{mk(CMD_PACKET, DIR_INBOUND, SRV, 80, EXT, 1024, FLAGS_ACK, 9), 1,
        '{ST_IN_MISS, 0, 0, 0, 0}},
      '{mk(CMD_PACKET, DIR_OUTBOUND, INS + 1, 6000, SRV, 443, FLAGS_SYN, 65), 1,
        '{ST_OK, EXT, 1024, 0, 0}},
      // Wrapped time on the all-ones flow reads as long idle; both old flows age.
      '{mk(CMD_TICK, DIR_OUTBOUND, 0, 0, 0, 0, 0, 70), 1, '{ST_TICK, 0, 0, 0, 2}},
      '{mk(CMD_PACKET, DIR_OUTBOUND, 0, 0, 0, 0, 0, 71), 1, '{ST_OK, EXT, 1025, 0, 0}},
      '{mk(CMD_TICK, DIR_INBOUND, '1, '1, '1, '1, '1, 72), 1, '{ST_TICK, 0, 0, 0, 0}},
      '{mk(CMD_PACKET, DIR_INBOUND, $urandom, $urandom, $urandom, $urandom, $urandom, 73),
        0, '{ST_OK, 0, 0, 0, 0}},
      '{mk(CMD_PACKET, DIR_OUTBOUND, $urandom, $urandom, $urandom, $urandom, $urandom, 74),
        0, '{ST_OK, 0, 0, 0, 0}}
    };
    foreach (directed_rows[i]) begin
      typed_next.push_back(directed_rows[i]);
      send(directed_rows[i].pkt);
    end
    idle_input(1);
    drain();

    // Phases: default range, port zero and a tiny range, empty range,
    // a flood that fills the table, and a narrow high range with fast aging.
    phases[0] = '{$urandom, 16'd1024, 16'd65535, 32'd60, 300, 10, 0};
    phases[1] = '{32'd0, 16'd0, 16'd4, 32'd0, 200, 15, 0};
    phases[2] = '{32'hFFFF_FFFF, 16'd65535, 16'd65535, 32'hFFFF_FFFF, 150, 10, 0};
    phases[3] = '{$urandom, 16'd1, 16'd65535, 32'd100000, 330, 90, 1};
    phases[4] = '{$urandom, 16'd60000, 16'd60010, 32'd5, 250, 15, 0};

    foreach (phases[k]) begin
      write_reg(REG_EXTERNAL_ADDR, phases[k].ext);
      write_reg(REG_PORT_LOW, {16'd0, phases[k].low});
      write_reg(REG_PORT_HIGH, {16'd0, phases[k].high});
      write_reg(REG_IDLE_TIMEOUT, phases[k].timeout);
      flow_pool.delete();
      burst = 0;
      for (int n = 0; n < phases[k].items; n++) begin
        // Hold off the result side for a long stretch while items keep coming.
        if (k == 0 && n == phases[k].items / 2) hold_req = 1'b1;
        // Pause the input until the block has returned everything.
        if (k == 0 && n == phases[k].items / 3) begin
          idle_input(1);
          drain();
        end
        if (burst == 0) begin
          burst = $urandom_range(1, 30);
          if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 12));
        end
        burst--;
        p = next_packet(phases[k]);
        send(p);
      end
      idle_input(1);
      drain();
    end

    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("nat_port_translation_table_core verification clean");
    end else begin
      $display("nat_port_translation_table_core verification failed");
    end
    $finish;
  end

endmodule
